/* design/nau_pkg.sv */
// Shared types, constants and arithmetic helpers for the activation unit.
package nau_pkg;

  localparam int FRAC_BITS = 12;
  localparam int DATA_W    = 16;
  localparam int E_W       = 13;   // exp value, at most 1.0
  localparam int Q_W       = 13;   // divider quotient bits
  localparam int NUM_W     = 26;   // divider dividend width
  localparam int DEN_W     = 14;   // divider divisor width
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 15;
  localparam int LEAK_W    = 13;
  localparam int ALPHA_W   = 15;

  localparam logic [E_W-1:0] ONE = E_W'(1 << FRAC_BITS);

  typedef enum logic [2:0] {
    FN_SIGMOID = 3'd0,
    FN_TANH    = 3'd1,
    FN_RELU    = 3'd2,
    FN_IDENT   = 3'd3,
    FN_LEAKY   = 3'd4,
    FN_SMOOTH  = 3'd5,
    FN_ELU     = 3'd6
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FUNC  = 3'd0,
    REG_DERIV = 3'd1,
    REG_LEAK  = 3'd2,
    REG_ALPHA = 3'd3
  } reg_idx_t;

  // round half away from zero of p / 2^sh
  function automatic logic signed [47:0] rnd_shift(input logic signed [47:0] p,
                                                   input int sh);
    logic signed [47:0] mag;
    logic signed [47:0] r;
    mag = p[47] ? -p : p;
    r   = (mag + (48'sd1 <<< (sh - 1))) >>> sh;
    return p[47] ? -r : r;
  endfunction

  // truncating unsigned quotient by shift and subtract, table build only
  function automatic longint unsigned udiv_u64(input longint unsigned n,
                                               input longint unsigned dv);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= dv) begin
        rem  = rem - dv;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-8*idx/2^seg_log) in Q12, built from a Q30 Taylor series of one step
  function automatic logic [E_W-1:0] exp_rom_entry(input int seg_log, input int idx);
    longint unsigned t;
    longint unsigned term;
    longint r;
    longint v;
    logic [E_W-1:0] e;
    t    = 64'd1 << (33 - seg_log);
    term = 64'd1 << 30;
    r    = 64'sd1 <<< 30;
    v    = 64'sd1 <<< 30;
    e    = ONE;
    for (int k = 1; k <= 24; k++) begin
      term = udiv_u64((term * t) >> 30, 64'(k));
      if (k % 2 == 1) begin
        r = r - longint'(term);
      end else begin
        r = r + longint'(term);
      end
    end
    for (int i = 1; i <= idx; i++) begin
      v = (v * r + (64'sd1 <<< 29)) >>> 30;
      e = E_W'((v + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
    end
    return e;
  endfunction

endpackage

/* design/nau_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module nau_div #(
  parameter int SIDE_W = 29
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [nau_pkg::NUM_W-1:0]   in_num,
  input  logic [nau_pkg::DEN_W-1:0]   in_den,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [nau_pkg::Q_W-1:0]     out_quo,
  output logic [SIDE_W-1:0]           out_side
);

  localparam int QW = nau_pkg::Q_W;
  localparam int NW = nau_pkg::NUM_W;
  localparam int DW = nau_pkg::DEN_W;

  logic          vld_r  [QW];
  logic [NW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [SIDE_W-1:0] side_r [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int SH = QW - 1 - j;
    logic          vld_in;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [SIDE_W-1:0] side_in;
    logic [NW:0]   trial;
    logic [NW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (j == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign den_in  = den_r[j-1];
      assign quo_in  = quo_r[j-1];
      assign side_in = side_r[j-1];
    end

    always_comb begin
      trial   = {1'b0, rem_in} - ((NW+1)'(den_in) << SH);
      rem_nxt = trial[NW] ? rem_in : trial[NW-1:0];
      quo_nxt = quo_in;
      quo_nxt[SH] = ~trial[NW];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        den_r[j]  <= den_in;
        quo_r[j]  <= quo_nxt;
        side_r[j] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

/* design/neural_activation_unit.sv */
// Activation unit top level: exp table, divider, product and output stages.
// One word enters per cycle while in_stall is low, and its result leaves from the
// output register; the 13-stage divider that forms sigmoid and tanh is most of the pipe.
// All stages advance together; in_stall rises only while a result sits in
// the output register with out_stall high. EXP_SEGMENTS must be a power of
// two. Configuration writes are taken every cycle (cfg_ready is always high)
// and must only happen while the pipeline is empty.
module neural_activation_unit #(
  parameter int EXP_SEGMENTS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [15:0]               in_operand,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [15:0]               out_result,
  output logic                             out_saturated,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nau_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nau_pkg::CFG_DAT_W-1:0]    cfg_data
);

  localparam int SEG_LOG = $clog2(EXP_SEGMENTS);
  localparam int W_LOG   = 15 - SEG_LOG;
  localparam int IDX_W   = SEG_LOG + 1;
  localparam int EW      = nau_pkg::E_W;
  localparam int SIDE_W  = 16 + EW;
  localparam int VW      = 34;
  localparam logic signed [VW-1:0] V_ONE = VW'(1 << nau_pkg::FRAC_BITS);

  // ---------------- configuration ----------------
  logic [2:0]                    fsel_r;
  logic                          deriv_r;
  logic [nau_pkg::LEAK_W-1:0]    leak_r;
  logic [nau_pkg::ALPHA_W-1:0]   alpha_r;
  nau_pkg::func_t                fsel;

  assign cfg_ready = 1'b1;
  assign fsel      = nau_pkg::func_t'(fsel_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsel_r  <= nau_pkg::FN_SIGMOID;
      deriv_r <= 1'b0;
      leak_r  <= nau_pkg::LEAK_W'(41);
      alpha_r <= nau_pkg::ALPHA_W'(4096);
    end else if (cfg_valid) begin
      case (nau_pkg::reg_idx_t'(cfg_index))
        nau_pkg::REG_FUNC:  fsel_r  <= cfg_data[2:0];
        nau_pkg::REG_DERIV: deriv_r <= cfg_data[0];
        nau_pkg::REG_LEAK:  leak_r  <= cfg_data[nau_pkg::LEAK_W-1:0];
        nau_pkg::REG_ALPHA: alpha_r <= cfg_data[nau_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- exp table ----------------
  logic [EW-1:0] rom_w [EXP_SEGMENTS+1];
  for (genvar g = 0; g <= EXP_SEGMENTS; g++) begin : g_rom
    assign rom_w[g] = nau_pkg::exp_rom_entry(SEG_LOG, g);
  end

  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // ---------------- stage 1: segment lookup ----------------
  logic [16:0]      mag;
  logic [17:0]      d_raw;
  logic [15:0]      d;
  logic [IDX_W-1:0] seg;
  logic [EW-1:0]    a_nxt, b_nxt;
  logic [W_LOG-1:0] fr_nxt;

  always_comb begin
    mag   = in_operand[15] ? 17'(-$signed({in_operand[15], in_operand}))
                           : {1'b0, in_operand};
    d_raw = (fsel == nau_pkg::FN_TANH) ? {mag, 1'b0} : {1'b0, mag};
    d     = (d_raw > 18'd32768) ? 16'h8000 : d_raw[15:0];
    seg   = d[15:W_LOG];
    if (seg[SEG_LOG]) begin
      a_nxt  = rom_w[EXP_SEGMENTS];
      b_nxt  = rom_w[EXP_SEGMENTS];
      fr_nxt = '0;
    end else begin
      a_nxt  = rom_w[seg];
      b_nxt  = rom_w[seg + IDX_W'(1)];
      fr_nxt = d[W_LOG-1:0];
    end
  end

  logic               v1_r;
  logic signed [15:0] z1_r;
  logic [EW-1:0]      a1_r, b1_r;
  logic [W_LOG-1:0]   fr1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1_r  <= in_operand;
      a1_r  <= a_nxt;
      b1_r  <= b_nxt;
      fr1_r <= fr_nxt;
    end
  end

  // ---------------- stage 2: interpolate ----------------
  logic [EW+W_LOG-1:0] ip;
  logic [EW+W_LOG-1:0] ip_rnd;
  logic [EW-1:0]       e_nxt;

  always_comb begin
    ip     = (EW+W_LOG)'(a1_r - b1_r) * (EW+W_LOG)'(fr1_r);
    ip_rnd = (ip + (EW+W_LOG)'(1 << (W_LOG - 1))) >> W_LOG;
    e_nxt  = a1_r - ip_rnd[EW-1:0];
  end

  logic               v2_r;
  logic signed [15:0] z2_r;
  logic [EW-1:0]      e2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z2_r <= z1_r;
      e2_r <= e_nxt;
    end
  end

  // ---------------- divider ----------------
  logic [nau_pkg::DEN_W-1:0] den;
  logic [nau_pkg::NUM_W-1:0] num;
  logic                      v4;
  logic [nau_pkg::Q_W-1:0]   q4;
  logic [SIDE_W-1:0]         side4;

  always_comb begin
    den = nau_pkg::DEN_W'(nau_pkg::ONE) + nau_pkg::DEN_W'(e2_r);
    if (fsel == nau_pkg::FN_TANH) begin
      num = {1'b0, nau_pkg::ONE - e2_r, 12'b0};
    end else begin
      num = nau_pkg::NUM_W'(1 << (2 * nau_pkg::FRAC_BITS));
    end
    num = num + nau_pkg::NUM_W'(den >> 1);
  end

  nau_div #(.SIDE_W(SIDE_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .in_num    (num),
    .in_den    (den),
    .in_side   ({z2_r, e2_r}),
    .out_valid (v4),
    .out_quo   (q4),
    .out_side  (side4)
  );

  logic signed [15:0] z4;
  logic [EW-1:0]      e4;
  assign z4 = side4[SIDE_W-1:EW];
  assign e4 = side4[EW-1:0];

  // ---------------- P1: sigmoid/tanh sign, ELU product ----------------
  logic [EW-1:0]      s_nxt;
  logic signed [13:0] t_nxt;
  logic signed [13:0] elu_m;
  logic signed [29:0] elu_nxt;

  always_comb begin
    s_nxt   = z4[15] ? nau_pkg::ONE - q4 : q4;
    t_nxt   = z4[15] ? -$signed({1'b0, q4}) : $signed({1'b0, q4});
    elu_m   = deriv_r ? $signed({1'b0, e4})
                      : $signed({1'b0, e4}) - $signed({1'b0, nau_pkg::ONE});
    elu_nxt = 30'($signed({1'b0, alpha_r})) * 30'(elu_m);
  end

  logic               v5_r;
  logic signed [15:0] z5_r;
  logic [EW-1:0]      s5_r;
  logic signed [13:0] t5_r;
  logic signed [29:0] elu5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z5_r   <= z4;
      s5_r   <= s_nxt;
      t5_r   <= t_nxt;
      elu5_r <= elu_nxt;
    end
  end

  // ---------------- P2: first products ----------------
  logic [25:0]        sd_nxt;
  logic signed [29:0] zs_nxt;
  logic signed [27:0] tt_nxt;
  logic signed [29:0] lz_nxt;

  always_comb begin
    sd_nxt = 26'(s5_r) * 26'(nau_pkg::ONE - s5_r);
    zs_nxt = 30'(z5_r) * 30'($signed({1'b0, s5_r}));
    tt_nxt = 28'(t5_r) * 28'(t5_r);
    lz_nxt = 30'(z5_r) * 30'($signed({1'b0, leak_r}));
  end

  logic               v6_r;
  logic signed [15:0] z6_r;
  logic [EW-1:0]      s6_r;
  logic signed [13:0] t6_r;
  logic signed [29:0] elu6_r;
  logic [25:0]        sd6_r;
  logic signed [29:0] zs6_r;
  logic signed [27:0] tt6_r;
  logic signed [29:0] lz6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z6_r   <= z5_r;
      s6_r   <= s5_r;
      t6_r   <= t5_r;
      elu6_r <= elu5_r;
      sd6_r  <= sd_nxt;
      zs6_r  <= zs_nxt;
      tt6_r  <= tt_nxt;
      lz6_r  <= lz_nxt;
    end
  end

  // ---------------- P3: smooth relu derivative product ----------------
  logic signed [42:0] zsd_nxt;
  assign zsd_nxt = 43'(z6_r) * 43'($signed({1'b0, sd6_r}));

  logic               v7_r;
  logic signed [15:0] z7_r;
  logic [EW-1:0]      s7_r;
  logic signed [13:0] t7_r;
  logic signed [29:0] elu7_r;
  logic [25:0]        sd7_r;
  logic signed [29:0] zs7_r;
  logic signed [27:0] tt7_r;
  logic signed [29:0] lz7_r;
  logic signed [42:0] zsd7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z7_r   <= z6_r;
      s7_r   <= s6_r;
      t7_r   <= t6_r;
      elu7_r <= elu6_r;
      sd7_r  <= sd6_r;
      zs7_r  <= zs6_r;
      tt7_r  <= tt6_r;
      lz7_r  <= lz6_r;
      zsd7_r <= zsd_nxt;
    end
  end

  // ---------------- P4: round and select ----------------
  logic                 pos;
  logic signed [VW-1:0] zv;
  logic signed [VW-1:0] sv;
  logic signed [VW-1:0] vv;

  always_comb begin
    pos = !z7_r[15] && (z7_r != 16'sd0);
    zv  = VW'(z7_r);
    sv  = VW'($signed({1'b0, s7_r}));
    case (fsel)
      nau_pkg::FN_SIGMOID:
        vv = deriv_r ? VW'(nau_pkg::rnd_shift(48'($signed({1'b0, sd7_r})), 12)) : sv;
      nau_pkg::FN_TANH:
        vv = deriv_r ? V_ONE - VW'(nau_pkg::rnd_shift(48'(tt7_r), 12)) : VW'(t7_r);
      nau_pkg::FN_RELU:
        vv = pos ? (deriv_r ? V_ONE : zv) : '0;
      nau_pkg::FN_IDENT:
        vv = deriv_r ? V_ONE : zv;
      nau_pkg::FN_LEAKY:
        if (pos) begin
          vv = deriv_r ? V_ONE : zv;
        end else begin
          vv = deriv_r ? VW'($signed({1'b0, leak_r}))
                       : VW'(nau_pkg::rnd_shift(48'(lz7_r), 12));
        end
      nau_pkg::FN_SMOOTH:
        vv = deriv_r ? sv + VW'(nau_pkg::rnd_shift(48'(zsd7_r), 24))
                     : VW'(nau_pkg::rnd_shift(48'(zs7_r), 12));
      nau_pkg::FN_ELU:
        if (pos) begin
          vv = deriv_r ? V_ONE : zv;
        end else begin
          vv = VW'(nau_pkg::rnd_shift(48'(elu7_r), 12));
        end
      default: vv = '0;
    endcase
  end

  logic                 v8_r;
  logic signed [VW-1:0] vv8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vv8_r <= vv;
    end
  end

  // ---------------- output: saturate ----------------
  logic signed [15:0] res_nxt;
  logic               sat_nxt;
  logic signed [15:0] out_result_r;
  logic               out_saturated_r;

  always_comb begin
    if (vv8_r > VW'(32767)) begin
      res_nxt = 16'sh7fff;
      sat_nxt = 1'b1;
    end else if (vv8_r < -VW'(32768)) begin
      res_nxt = 16'sh8000;
      sat_nxt = 1'b1;
    end else begin
      res_nxt = vv8_r[15:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result_r    <= res_nxt;
      out_saturated_r <= sat_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result    = out_result_r;
  assign out_saturated = out_saturated_r;

endmodule

/* design/nau_checker.sv */
// Port-level assertions for the activation unit, bound to the top level.
module nau_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic signed [15:0]            in_operand,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [15:0]            out_result,
  input logic                          out_saturated,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [nau_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [nau_pkg::CFG_DAT_W-1:0] cfg_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result) && $stable(out_saturated))
    else $error("result word changed under stall");

  // saturation flag only with a clamped value
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> (out_result == 16'sh7fff || out_result == 16'sh8000))
    else $error("saturated flag with unclamped result");

  // input stalls exactly when a held result blocks the pipeline
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind neural_activation_unit nau_checker u_nau_checker (.*);
